FILE: rtl/bair_pkg.sv
`default_nettype none

package bair_pkg;

   // source store geometry
   localparam int MAX_SRC_WIDTH  = 64;
   localparam int MAX_SRC_HEIGHT = 64;
   localparam int MAX_DST_DIM    = 1024;
   localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int STORE_AW       = $clog2(STORE_DEPTH);
   localparam int PIXEL_W        = 32;

   // field and register widths
   localparam int CHAN_W  = 8;
   localparam int COORD_W = 10;
   localparam int SRC_W   = 7;
   localparam int DST_W   = 11;

   // box bounds, sample count and channel sums
   localparam int BND_W  = $clog2(((MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                                   MAX_SRC_WIDTH : MAX_SRC_HEIGHT) + 1);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W  = $clog2(STORE_DEPTH * 255 + 1);
   localparam int PROD_W = (COORD_W + 1) + SRC_W;

   // shared divider: quotient is always below 256
   localparam int QW      = 8;
   localparam int STEP_W  = $clog2(QW);
   localparam int DIV_A_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int DIV_B_W = CNT_W + QW - 1;
   localparam int DIV_W   = (DIV_A_W > DIV_B_W) ? DIV_A_W : DIV_B_W;

   // csr map
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 4;
   localparam int CSR_IW = 2;

   localparam logic [CSR_IW-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IW-1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IW-1:0] REG_DST_HEIGHT = 2'd3;

   localparam logic [SRC_W-1:0] SRC_RESET = SRC_W'(64);
   localparam logic [DST_W-1:0] DST_RESET = DST_W'(64);

   // request operations
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/bair_ram.sv
`default_nettype none

module bair_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/box_average_image_rescaler_unit.sv
`default_nettype none

// channel   handshake               payload
// ------------------------------------------------------------------------
// req       req_valid / req_ready   operation, col, row, blue, green, red, alpha
// rsp       rsp_valid / rsp_ready   avg_blue, avg_green, avg_red, avg_alpha,
//                                   out_of_range
// csr       psel / penable / pwrite src_width, src_height, dst_width, dst_height
//
// A read runs four box-bound divisions and four channel divisions on the one
// shared restoring divider, plus one store read per box pixel.
// Reset is synchronous; it sets the size registers to 64, the store keeps its
// contents. req_ready is high only while idle; a finished result waits in the
// rsp register while the next request is accepted and worked on.

module box_average_image_rescaler_unit
   import bair_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic              req_operation,
   input  wire logic [COORD_W-1:0] req_col,
   input  wire logic [COORD_W-1:0] req_row,
   input  wire logic [CHAN_W-1:0] req_blue,
   input  wire logic [CHAN_W-1:0] req_green,
   input  wire logic [CHAN_W-1:0] req_red,
   input  wire logic [CHAN_W-1:0] req_alpha,

   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [CHAN_W-1:0] rsp_avg_blue,
   output      logic [CHAN_W-1:0] rsp_avg_green,
   output      logic [CHAN_W-1:0] rsp_avg_red,
   output      logic [CHAN_W-1:0] rsp_avg_alpha,
   output      logic              rsp_out_of_range,

   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output      logic [CSR_DW-1:0] csr_prdata,
   output      logic              csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_DIV,
      S_WALK,
      S_DRAIN,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      JOB_Y0,
      JOB_Y1,
      JOB_X0,
      JOB_X1,
      JOB_BLUE,
      JOB_GREEN,
      JOB_RED,
      JOB_ALPHA
   } job_type;

   // size registers
   logic [SRC_W-1:0] src_width_ff;
   logic [SRC_W-1:0] src_height_ff;
   logic [DST_W-1:0] dst_width_ff;
   logic [DST_W-1:0] dst_height_ff;

   // clamped sizes
   logic [SRC_W-1:0] src_w_eff;
   logic [SRC_W-1:0] src_h_eff;
   logic [DST_W-1:0] dst_w_eff;
   logic [DST_W-1:0] dst_h_eff;

   // sequencer and datapath registers
   state_type          state_ff;
   job_type            job_ff;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] row_ff;
   logic               flag_ff;
   logic [CHAN_W-1:0]  avg_ff [4];
   logic [BND_W-1:0]   y0_ff;
   logic [BND_W-1:0]   y1_ff;
   logic [BND_W-1:0]   x0_ff;
   logic [BND_W-1:0]   x1_ff;
   logic [BND_W-1:0]   x_ff;
   logic [BND_W-1:0]   y_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [SUM_W-1:0]   sum_ff [4];
   logic               acc_vld_ff;

   // divider registers
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  dsr_ff;
   logic [QW-1:0]     q_ff;
   logic [STEP_W-1:0] step_ff;

   // result register
   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_avg_ff [4];
   logic              rsp_flag_ff;

   // combinational helpers
   logic                  req_fire;
   logic                  wr_in_range;
   logic                  rd_in_range;
   logic                  div_ge;
   logic [DIV_W-1:0]      rem_in;
   logic [QW-1:0]         q_in;
   logic [COORD_W:0]      mul_a;
   logic [SRC_W-1:0]      mul_b;
   logic [PROD_W-1:0]     product;
   logic [DIV_W-1:0]      dividend;
   logic [DIV_W-1:0]      divisor;
   logic                  ram_we;
   logic [STORE_AW-1:0]   ram_waddr;
   logic [PIXEL_W-1:0]    ram_wdata;
   logic [STORE_AW-1:0]   ram_raddr;
   logic [PIXEL_W-1:0]    ram_rdata;
   logic [CSR_IW-1:0]     csr_index;

   // upper box bound: at least lo+1, at most the source size
   function automatic logic [BND_W-1:0] box_hi(input logic [QW-1:0]    q,
                                               input logic [BND_W-1:0] lo,
                                               input logic [SRC_W-1:0] s);
      logic [QW-1:0] lo1;
      logic [QW-1:0] b;
      lo1 = QW'(lo) + QW'(1);
      b   = (q < lo1) ? lo1 : q;
      if (b > QW'(s)) begin
         b = QW'(s);
      end
      return BND_W'(b);
   endfunction

   // size clamping
   always_comb begin
      src_w_eff = (src_width_ff == '0) ? SRC_W'(1) :
                  (src_width_ff > SRC_W'(MAX_SRC_WIDTH)) ? SRC_W'(MAX_SRC_WIDTH) :
                  src_width_ff;
      src_h_eff = (src_height_ff == '0) ? SRC_W'(1) :
                  (src_height_ff > SRC_W'(MAX_SRC_HEIGHT)) ? SRC_W'(MAX_SRC_HEIGHT) :
                  src_height_ff;
      dst_w_eff = (dst_width_ff == '0) ? DST_W'(1) :
                  (dst_width_ff > DST_W'(MAX_DST_DIM)) ? DST_W'(MAX_DST_DIM) :
                  dst_width_ff;
      dst_h_eff = (dst_height_ff == '0) ? DST_W'(1) :
                  (dst_height_ff > DST_W'(MAX_DST_DIM)) ? DST_W'(MAX_DST_DIM) :
                  dst_height_ff;
   end

   // csr port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_AW-1:2];

   always_comb begin
      case (csr_index)
         REG_SRC_WIDTH:  csr_prdata = CSR_DW'(src_width_ff);
         REG_SRC_HEIGHT: csr_prdata = CSR_DW'(src_height_ff);
         REG_DST_WIDTH:  csr_prdata = CSR_DW'(dst_width_ff);
         REG_DST_HEIGHT: csr_prdata = CSR_DW'(dst_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_RESET;
         src_height_ff <= SRC_RESET;
         dst_width_ff  <= DST_RESET;
         dst_height_ff <= DST_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_index)
            REG_SRC_WIDTH:  src_width_ff  <= csr_pwdata[SRC_W-1:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_pwdata[SRC_W-1:0];
            REG_DST_WIDTH:  dst_width_ff  <= csr_pwdata[DST_W-1:0];
            REG_DST_HEIGHT: dst_height_ff <= csr_pwdata[DST_W-1:0];
            default: ;
         endcase
      end
   end

   // request acceptance and range checks
   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign wr_in_range = ({1'b0, req_col} < (COORD_W+1)'(src_w_eff)) &&
                        ({1'b0, req_row} < (COORD_W+1)'(src_h_eff));
   assign rd_in_range = ((COORD_W+1)'(req_col) < (COORD_W+1)'(dst_w_eff)) &&
                        ((COORD_W+1)'(req_row) < (COORD_W+1)'(dst_h_eff));

   // source store
   assign ram_we    = req_fire && (req_operation == OP_WRITE) && wr_in_range;
   assign ram_waddr = STORE_AW'(req_row * MAX_SRC_WIDTH + req_col);
   assign ram_wdata = {req_alpha, req_red, req_green, req_blue};
   assign ram_raddr = STORE_AW'(y_ff * MAX_SRC_WIDTH + x_ff);

   bair_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // operand select: scaled coordinate for box bounds, channel sum for means
   always_comb begin
      case (job_ff)
         JOB_Y0:  mul_a = {1'b0, row_ff};
         JOB_Y1:  mul_a = {1'b0, row_ff} + (COORD_W+1)'(1);
         JOB_X0:  mul_a = {1'b0, col_ff};
         JOB_X1:  mul_a = {1'b0, col_ff} + (COORD_W+1)'(1);
         default: mul_a = '0;
      endcase
      mul_b   = (job_ff == JOB_Y0 || job_ff == JOB_Y1) ? src_h_eff : src_w_eff;
      product = PROD_W'(mul_a) * PROD_W'(mul_b);
      case (job_ff)
         JOB_Y0, JOB_Y1, JOB_X0, JOB_X1: begin
            dividend = DIV_W'(product);
            divisor  = (job_ff == JOB_Y0 || job_ff == JOB_Y1) ? DIV_W'(dst_h_eff) :
                       DIV_W'(dst_w_eff);
         end
         default: begin
            dividend = DIV_W'(sum_ff[job_ff[1:0]]);
            divisor  = DIV_W'(count_ff);
         end
      endcase
   end

   // one restoring divider step
   assign div_ge = (rem_ff >= dsr_ff);
   assign rem_in = div_ge ? (rem_ff - dsr_ff) : rem_ff;
   assign q_in   = {q_ff[QW-2:0], div_ge};

   // sequencer, divider, box walk and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= JOB_Y0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_vld_ff <= (state_ff == S_WALK);

         // accumulate the pixel read in the previous cycle
         if (acc_vld_ff) begin
            for (int c = 0; c < 4; c++) begin
               sum_ff[c] <= sum_ff[c] + SUM_W'(ram_rdata[CHAN_W*c +: CHAN_W]);
            end
         end

         // result taken while no new one is being loaded
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  col_ff <= req_col;
                  row_ff <= req_row;
                  for (int c = 0; c < 4; c++) begin
                     avg_ff[c] <= '0;
                  end
                  job_ff <= JOB_Y0;
                  if (req_operation == OP_WRITE) begin
                     flag_ff  <= !wr_in_range;
                     state_ff <= S_DONE;
                  end else if (!rd_in_range) begin
                     flag_ff  <= 1'b1;
                     state_ff <= S_DONE;
                  end else begin
                     flag_ff  <= 1'b0;
                     state_ff <= S_LOAD;
                  end
               end
            end

            S_LOAD: begin
               rem_ff   <= dividend;
               dsr_ff   <= divisor << (QW - 1);
               q_ff     <= '0;
               step_ff  <= '0;
               state_ff <= S_DIV;
            end

            S_DIV: begin
               rem_ff  <= rem_in;
               dsr_ff  <= dsr_ff >> 1;
               q_ff    <= q_in;
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(QW - 1)) begin
                  job_ff <= job_type'(job_ff + 3'd1);
                  case (job_ff)
                     JOB_Y0: begin
                        y0_ff    <= BND_W'(q_in);
                        state_ff <= S_LOAD;
                     end
                     JOB_Y1: begin
                        y1_ff    <= box_hi(q_in, y0_ff, src_h_eff);
                        state_ff <= S_LOAD;
                     end
                     JOB_X0: begin
                        x0_ff    <= BND_W'(q_in);
                        state_ff <= S_LOAD;
                     end
                     JOB_X1: begin
                        x1_ff    <= box_hi(q_in, x0_ff, src_w_eff);
                        x_ff     <= x0_ff;
                        y_ff     <= y0_ff;
                        count_ff <= '0;
                        for (int c = 0; c < 4; c++) begin
                           sum_ff[c] <= '0;
                        end
                        state_ff <= S_WALK;
                     end
                     JOB_ALPHA: begin
                        avg_ff[3] <= q_in;
                        state_ff  <= S_DONE;
                     end
                     default: begin
                        avg_ff[job_ff[1:0]] <= q_in;
                        state_ff            <= S_LOAD;
                     end
                  endcase
               end
            end

            // one store read a cycle, row by row through the box
            S_WALK: begin
               count_ff <= count_ff + CNT_W'(1);
               if (x_ff + BND_W'(1) == x1_ff) begin
                  x_ff <= x0_ff;
                  if (y_ff + BND_W'(1) == y1_ff) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     y_ff <= y_ff + BND_W'(1);
                  end
               end else begin
                  x_ff <= x_ff + BND_W'(1);
               end
            end

            S_DRAIN: begin
               job_ff   <= JOB_BLUE;
               state_ff <= S_LOAD;
            end

            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  for (int c = 0; c < 4; c++) begin
                     rsp_avg_ff[c] <= avg_ff[c];
                  end
                  rsp_flag_ff <= flag_ff;
                  state_ff    <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_avg_blue     = rsp_avg_ff[0];
   assign rsp_avg_green    = rsp_avg_ff[1];
   assign rsp_avg_red      = rsp_avg_ff[2];
   assign rsp_avg_alpha    = rsp_avg_ff[3];
   assign rsp_out_of_range = rsp_flag_ff;

endmodule

`default_nettype wire

FILE: verif/tb_box_average_image_rescaler_unit.sv
`timescale 1ns / 1ps

module tb_box_average_image_rescaler_unit;
   import bair_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 200;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic               operation;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  alpha;
   } pixel_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] avg_blue;
      logic [CHAN_W-1:0] avg_green;
      logic [CHAN_W-1:0] avg_red;
      logic [CHAN_W-1:0] avg_alpha;
      logic              out_of_range;
   } pixel_rsp_type;

   // dut ports, all inputs known from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = OP_WRITE;
   logic [COORD_W-1:0] req_col = '0;
   logic [COORD_W-1:0] req_row = '0;
   logic [CHAN_W-1:0] req_blue = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_red = '0;
   logic [CHAN_W-1:0] req_alpha = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_avg_blue;
   logic [CHAN_W-1:0] rsp_avg_green;
   logic [CHAN_W-1:0] rsp_avg_red;
   logic [CHAN_W-1:0] rsp_avg_alpha;
   logic              rsp_out_of_range;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // predictor state: size registers and source image copy
   logic [SRC_W-1:0]  cfg_src_w = SRC_RESET;
   logic [SRC_W-1:0]  cfg_src_h = SRC_RESET;
   logic [DST_W-1:0]  cfg_dst_w = DST_RESET;
   logic [DST_W-1:0]  cfg_dst_h = DST_RESET;
   logic [PIXEL_W-1:0] source_pixels [STORE_DEPTH];
   bit                pixel_written [STORE_DEPTH];

   pixel_req_type     pixel_requests_q [$];
   pixel_rsp_type     expected_pixels_q [$];
   pixel_req_type     next_request;

   int unsigned       send_idle_pct = 0;
   int unsigned       recv_stall_pct = 0;
   bit                hold_start = 1'b0;
   int unsigned       hold_left = 0;
   int unsigned       cycle_count = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       reads_seen = 0;
   int unsigned       writes_seen = 0;
   int unsigned       flagged_seen = 0;
   int unsigned       settings_applied = 0;

   box_average_image_rescaler_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_blue         (req_blue),
      .req_green        (req_green),
      .req_red          (req_red),
      .req_alpha        (req_alpha),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_avg_blue     (rsp_avg_blue),
      .rsp_avg_green    (rsp_avg_green),
      .rsp_avg_red      (rsp_avg_red),
      .rsp_avg_alpha    (rsp_avg_alpha),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // sizes below 1 or above the maximum saturate
   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned src_w_eff();
      return clamp_dim(cfg_src_w, MAX_SRC_WIDTH);
   endfunction

   function automatic int unsigned src_h_eff();
      return clamp_dim(cfg_src_h, MAX_SRC_HEIGHT);
   endfunction

   function automatic int unsigned dst_w_eff();
      return clamp_dim(cfg_dst_w, MAX_DST_DIM);
   endfunction

   function automatic int unsigned dst_h_eff();
      return clamp_dim(cfg_dst_h, MAX_DST_DIM);
   endfunction

   // source span covered by destination index d, at least one sample wide
   function automatic void box_span(input int unsigned d, input int unsigned s,
                                    input int unsigned dn, output int unsigned lo,
                                    output int unsigned hi);
      lo = (d * s) / dn;
      hi = ((d + 1) * s) / dn;
      if (hi < lo + 1) hi = lo + 1;
      if (hi > s) hi = s;
   endfunction

   // expected result of one request; a write updates the image copy
   function automatic pixel_rsp_type predict_pixel(pixel_req_type rq);
      pixel_rsp_type res;
      int unsigned src_w, src_h, dst_w, dst_h;
      int unsigned x0, x1, y0, y1, count;
      int unsigned sums [4];
      logic [PIXEL_W-1:0] px;
      src_w = src_w_eff();
      src_h = src_h_eff();
      dst_w = dst_w_eff();
      dst_h = dst_h_eff();
      res = '0;
      count = 0;
      sums = '{0, 0, 0, 0};
      if (rq.operation == OP_WRITE) begin
         if (rq.col >= src_w || rq.row >= src_h) begin
            res.out_of_range = 1'b1;
         end else begin
            source_pixels[rq.row * MAX_SRC_WIDTH + rq.col] =
               {rq.alpha, rq.red, rq.green, rq.blue};
         end
      end else if (rq.col >= dst_w || rq.row >= dst_h) begin
         res.out_of_range = 1'b1;
      end else begin
         box_span(rq.row, src_h, dst_h, y0, y1);
         box_span(rq.col, src_w, dst_w, x0, x1);
         for (int unsigned y = y0; y < y1; y++) begin
            for (int unsigned x = x0; x < x1; x++) begin
               px = source_pixels[y * MAX_SRC_WIDTH + x];
               for (int c = 0; c < 4; c++) sums[c] += px[8*c +: 8];
               count++;
            end
         end
         res.avg_blue  = CHAN_W'(sums[0] / count);
         res.avg_green = CHAN_W'(sums[1] / count);
         res.avg_red   = CHAN_W'(sums[2] / count);
         res.avg_alpha = CHAN_W'(sums[3] / count);
      end
      return res;
   endfunction

   // queue a pixel write; in-range writes make that pixel safe to read
   task automatic add_write(int unsigned col, int unsigned row, int unsigned b,
                            int unsigned g, int unsigned r, int unsigned a);
      pixel_req_type rq;
      rq = '{OP_WRITE, COORD_W'(col), COORD_W'(row), CHAN_W'(b), CHAN_W'(g),
             CHAN_W'(r), CHAN_W'(a)};
      if (col < src_w_eff() && row < src_h_eff())
         pixel_written[row * MAX_SRC_WIDTH + col] = 1'b1;
      pixel_requests_q.push_back(rq);
   endtask

   // queue a read, first writing any box pixel not yet stored
   task automatic add_read(int unsigned col, int unsigned row);
      pixel_req_type rq;
      int unsigned   x0, x1, y0, y1;
      if (col < dst_w_eff() && row < dst_h_eff()) begin
         box_span(row, src_h_eff(), dst_h_eff(), y0, y1);
         box_span(col, src_w_eff(), dst_w_eff(), x0, x1);
         for (int unsigned y = y0; y < y1; y++)
            for (int unsigned x = x0; x < x1; x++)
               if (!pixel_written[y * MAX_SRC_WIDTH + x])
                  add_write(x, y, $urandom_range(255), $urandom_range(255),
                            $urandom_range(255), $urandom_range(255));
      end
      rq = '{OP_READ, COORD_W'(col), COORD_W'(row), CHAN_W'($urandom_range(255)),
             CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
             CHAN_W'($urandom_range(255))};
      pixel_requests_q.push_back(rq);
   endtask

   // mostly in-range reads and writes, some anywhere in the coordinate space
   task automatic queue_random(int unsigned n);
      int unsigned col, row;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(99) < 50) begin
            if ($urandom_range(99) < 12) begin
               col = $urandom_range(1023);
               row = $urandom_range(1023);
            end else begin
               col = $urandom_range(dst_w_eff() - 1);
               row = $urandom_range(dst_h_eff() - 1);
            end
            add_read(col, row);
         end else begin
            if ($urandom_range(99) < 12) begin
               col = $urandom_range(1023);
               row = $urandom_range(1023);
            end else begin
               col = $urandom_range(src_w_eff() - 1);
               row = $urandom_range(src_h_eff() - 1);
            end
            add_write(col, row, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255));
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_requests_q.size() != 0 || req_valid || expected_pixels_q.size() != 0);
   endtask

   // apb write: setup cycle, then access cycle
   task automatic write_csr(logic [CSR_IW-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_SRC_WIDTH:  cfg_src_w = SRC_W'(value);
         REG_SRC_HEIGHT: cfg_src_h = SRC_W'(value);
         REG_DST_WIDTH:  cfg_dst_w = DST_W'(value);
         REG_DST_HEIGHT: cfg_dst_h = DST_W'(value);
         default: ;
      endcase
   endtask

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 74; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 74; end
         default:       begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
   endtask

   // one size setting: drain, reprogram, then random traffic
   task automatic run_phase(int unsigned src_w, int unsigned src_h, int unsigned dst_w,
                            int unsigned dst_h, idle_mode_type mode, int unsigned n,
                            bit hold, bit pause);
      wait_drained();
      write_csr(REG_SRC_WIDTH, src_w);
      write_csr(REG_SRC_HEIGHT, src_h);
      write_csr(REG_DST_WIDTH, dst_w);
      write_csr(REG_DST_HEIGHT, dst_h);
      settings_applied++;
      @(negedge clock);
      set_idling(mode);
      if (hold) hold_start = 1'b1;
      if (pause) begin
         queue_random(n / 2);
         wait_drained();
         queue_random(n - n / 2);
      end else begin
         queue_random(n);
      end
   endtask

   task automatic note_mismatch(string what, pixel_rsp_type want, pixel_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected b=%0d g=%0d r=%0d a=%0d oor=%0b, got b=%0d g=%0d r=%0d a=%0d oor=%0b",
                  $time, what, want.avg_blue, want.avg_green, want.avg_red,
                  want.avg_alpha, want.out_of_range, got.avg_blue, got.avg_green,
                  got.avg_red, got.avg_alpha, got.out_of_range);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pixel_requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_request = pixel_requests_q.pop_front();
            req_valid     <= 1'b1;
            req_operation <= next_request.operation;
            req_col       <= next_request.col;
            req_row       <= next_request.row;
            req_blue      <= next_request.blue;
            req_green     <= next_request.green;
            req_red       <= next_request.red;
            req_alpha     <= next_request.alpha;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver with random stalls and an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_start) begin
         hold_start = 1'b0;
         hold_left  = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_operation == OP_READ) reads_seen++;
            else writes_seen++;
            expected_pixels_q.push_back(predict_pixel('{req_operation, req_col, req_row,
               req_blue, req_green, req_red, req_alpha}));
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_out_of_range) flagged_seen++;
            if (expected_pixels_q.size() == 0) begin
               note_mismatch("unexpected result", '0, '{rsp_avg_blue, rsp_avg_green,
                  rsp_avg_red, rsp_avg_alpha, rsp_out_of_range});
            end else if ({rsp_avg_blue, rsp_avg_green, rsp_avg_red, rsp_avg_alpha,
                          rsp_out_of_range} !== expected_pixels_q[0]) begin
               note_mismatch("result mismatch", expected_pixels_q[0], '{rsp_avg_blue,
                  rsp_avg_green, rsp_avg_red, rsp_avg_alpha, rsp_out_of_range});
               void'(expected_pixels_q.pop_front());
            end else begin
               void'(expected_pixels_q.pop_front());
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset sizes: corners, refused writes and reads outside the destination
      add_write(0, 0, 0, 0, 0, 0);
      add_write(63, 63, 255, 255, 255, 255);
      add_write(63, 0, 8'h55, 8'haa, 8'h0f, 8'hf0);
      add_write(0, 63, 8'haa, 8'h55, 8'hf0, 8'h0f);
      add_write(64, 0, 1, 2, 3, 4);
      add_write(0, 64, 5, 6, 7, 8);
      add_write(1023, 1023, 255, 255, 255, 255);
      add_read(0, 0);
      add_read(63, 63);
      add_read(63, 0);
      add_read(0, 63);
      add_read(64, 0);
      add_read(0, 64);
      add_read(1023, 1023);

      // 4x4 reduction, no idling, receiver holds off so the input stalls
      run_phase(8, 8, 2, 2, IDLE_NONE, 120, 1'b1, 1'b0);
      // enlargement with an idle sender
      run_phase(4, 4, 13, 9, IDLE_SENDER, 120, 1'b0, 1'b0);
      // zero and all-ones register values: one column, 64-row boxes
      run_phase(0, 127, 2047, 1, IDLE_RECEIVER, 100, 1'b0, 1'b0);
      // one row, 64-column boxes
      run_phase(127, 0, 1, 2047, IDLE_BOTH, 100, 1'b0, 1'b0);
      // odd ratios, sender pauses mid-phase until all results are back
      run_phase(16, 3, 5, 7, IDLE_NONE, 100, 1'b0, 1'b1);
      // one to one at full source size
      run_phase(64, 64, 64, 64, IDLE_RECEIVER, 100, 1'b0, 1'b0);
      // destination width of zero saturates to one
      run_phase(6, 5, 0, 1023, IDLE_BOTH, 100, 1'b0, 1'b0);
      // single source pixel spread over the largest destination
      run_phase(1, 1, 1024, 1024, IDLE_SENDER, 80, 1'b0, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d reads and %0d writes over %0d size settings, %0d flagged",
               reads_seen, writes_seen, settings_applied, flagged_seen);
      $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
